// File: design/sfdc_pkg.sv
// ----------------------------------------------------------------------------
// sfdc_pkg
// Shared types and constants for the sensor frame deframer and checksum core.
// ----------------------------------------------------------------------------
package sfdc_pkg;

	// frame start marker and result field width
	localparam logic [7:0] START_MARK = 8'hFF;
	localparam int         CHANNEL_W  = 4;

	// input item payload
	typedef struct packed {
		logic [7:0] rx_byte;
	} in_item_t;

	// result item payload
	typedef struct packed {
		logic                 frame_ok;
		logic [CHANNEL_W-1:0] channel;
		logic [7:0]           value;
		logic                 last;
	} out_item_t;

	// controller to datapath commands
	typedef struct packed {
		logic clear_sum;
		logic store_en;
		logic load_data;
		logic load_reject;
		logic last;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic is_start;
		logic sum_match;
		logic out_free;
	} status_t;

endpackage

// File: design/sfdc_stream_if.sv
// ----------------------------------------------------------------------------
// sfdc_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface sfdc_stream_if #(
	parameter type payload_t = logic [7:0]
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: design/sfdc_ctrl.sv
// ----------------------------------------------------------------------------
// sfdc_ctrl
// Frame controller: hunts for the start marker, counts data bytes, checks the
// checksum byte and sequences the result burst.
// ----------------------------------------------------------------------------
module sfdc_ctrl #(
	parameter int NUM_CHANNELS = 10,
	parameter int IDX_W        = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  sfdc_pkg::status_t  st,
	output sfdc_pkg::cmd_t     cmd,
	output logic [IDX_W-1:0]   idx
);
	import sfdc_pkg::*;

	localparam logic [2:0] ST_HUNT   = 3'd0;
	localparam logic [2:0] ST_DATA   = 3'd1;
	localparam logic [2:0] ST_CHECK  = 3'd2;
	localparam logic [2:0] ST_EMIT   = 3'd3;
	localparam logic [2:0] ST_REJECT = 3'd4;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

	logic [2:0]       state_q, state_d;
	logic [IDX_W-1:0] cnt_q, cnt_d;
	logic             accept;

	// input is held off while results are being produced
	assign in_ready = (state_q != ST_EMIT) && (state_q != ST_REJECT);
	assign accept   = in_valid && in_ready;
	assign idx      = cnt_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		unique case (state_q)
			ST_HUNT, ST_DATA, ST_CHECK: begin
				if (accept) begin
					priority if (st.is_start) begin
						state_d       = ST_DATA;
						cnt_d         = '0;
						cmd.clear_sum = 1'b1;
					end else if (state_q == ST_DATA) begin
						cmd.store_en = 1'b1;
						if (cnt_q == LAST_IDX) begin
							state_d = ST_CHECK;
							cnt_d   = '0;
						end else begin
							cnt_d = cnt_q + 1'b1;
						end
					end else if (state_q == ST_CHECK) begin
						cnt_d   = '0;
						state_d = st.sum_match ? ST_EMIT : ST_REJECT;
					end else begin
						state_d = ST_HUNT;
					end
				end
			end
			ST_EMIT: begin
				if (st.out_free) begin
					cmd.load_data = 1'b1;
					cmd.last      = (cnt_q == LAST_IDX);
					if (cnt_q == LAST_IDX) begin
						state_d = ST_HUNT;
						cnt_d   = '0;
					end else begin
						cnt_d = cnt_q + 1'b1;
					end
				end
			end
			ST_REJECT: begin
				if (st.out_free) begin
					cmd.load_reject = 1'b1;
					state_d         = ST_HUNT;
				end
			end
			default: begin
				state_d = ST_HUNT;
				cnt_d   = '0;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

// File: design/sfdc_datapath.sv
// ----------------------------------------------------------------------------
// sfdc_datapath
// Frame byte store, running checksum, checksum compare and result register.
// ----------------------------------------------------------------------------
module sfdc_datapath #(
	parameter int NUM_CHANNELS = 10,
	parameter int IDX_W        = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          rx_byte,
	input  sfdc_pkg::cmd_t      cmd,
	input  logic [IDX_W-1:0]    idx,
	output sfdc_pkg::status_t   st,
	output logic                out_valid,
	input  logic                out_ready,
	output sfdc_pkg::out_item_t out_data
);
	import sfdc_pkg::*;

	logic [7:0] store_q [NUM_CHANNELS];
	logic [7:0] sum_q;
	logic [7:0] expect_sum;
	logic       out_valid_q;
	out_item_t  out_data_q;

	// a sum equal to the start marker is checked as zero
	assign expect_sum = (sum_q == START_MARK) ? 8'h00 : sum_q;

	assign st.is_start  = (rx_byte == START_MARK);
	assign st.sum_match = (rx_byte == expect_sum);
	assign st.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// running checksum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (cmd.clear_sum) begin
			sum_q <= '0;
		end else if (cmd.store_en) begin
			sum_q <= sum_q + rx_byte;
		end
	end

	// frame byte store
	always_ff @(posedge clk) begin
		if (cmd.store_en) begin
			store_q[idx] <= rx_byte;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_data || cmd.load_reject) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (cmd.load_data) begin
			out_data_q.frame_ok <= 1'b1;
			out_data_q.channel  <= CHANNEL_W'(idx);
			out_data_q.value    <= store_q[idx];
			out_data_q.last     <= cmd.last;
		end else if (cmd.load_reject) begin
			out_data_q.frame_ok <= 1'b0;
			out_data_q.channel  <= '0;
			out_data_q.value    <= '0;
			out_data_q.last     <= 1'b1;
		end
	end

endmodule

// File: design/sensor_frame_deframer_checksum_core.sv
// Receives serial bytes one per handshake and accepts one byte per clock cycle
// while collecting a frame: a 0xFF start byte, NUM_CHANNELS data bytes and one
// checksum byte (sum of the data bytes modulo 256, a sum of 0xFF checked as 0).
// A matching checksum byte starts a burst of NUM_CHANNELS results, one per
// cycle while the output is taken, the final one marked last; a mismatch gives
// one result with frame_ok low. The input is held off during the burst and the
// rejection result, so no new byte is taken until the last result has been
// loaded into the single result register, which the controller steps through
// the frame store. A start byte inside a frame restarts it; bytes outside a
// frame are dropped.
// ----------------------------------------------------------------------------
// sensor_frame_deframer_checksum_core
// Top level: controller and datapath of the sensor frame deframer.
// ----------------------------------------------------------------------------
module sensor_frame_deframer_checksum_core #(
	parameter int NUM_CHANNELS = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	sfdc_stream_if.sink       din,
	sfdc_stream_if.source     dout
);
	import sfdc_pkg::*;

	localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	cmd_t             cmd;
	status_t          st;
	logic [IDX_W-1:0] idx;
	logic             in_ready;
	logic             out_valid;
	out_item_t        out_data;

	assign din.ready  = in_ready;
	assign dout.valid = out_valid;
	assign dout.data  = out_data;

	// frame controller
	sfdc_ctrl #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.IDX_W        (IDX_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd),
		.idx      (idx)
	);

	// store, checksum and result register
	sfdc_datapath #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.IDX_W        (IDX_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_byte   (din.data.rx_byte),
		.cmd       (cmd),
		.idx       (idx),
		.st        (st),
		.out_valid (out_valid),
		.out_ready (dout.ready),
		.out_data  (out_data)
	);

	// a result is loaded only into a free result register
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_data || cmd.load_reject) |-> st.out_free)
		else $error("result loaded over a pending result");

	// no input byte is taken while a result is being loaded
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !(cmd.load_data || cmd.load_reject))
		else $error("input taken during result burst");

	// a rejection is a single zero result marked last
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.frame_ok) |->
		(out_data.last && out_data.value == 8'h00 && out_data.channel == '0))
		else $error("malformed rejection result");

	// the last good result carries the final channel
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.frame_ok && out_data.last) |->
		(out_data.channel == CHANNEL_W'(NUM_CHANNELS - 1)))
		else $error("last mark on wrong channel");

endmodule
